// ===== src/arc_pkg.sv =====
// Shared codes and types for the ARP responder with its address cache.
package arc_pkg;

  // Function codes carried by an input item.
  localparam logic [1:0] FUNC_PACKET  = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0] FUNC_RESOLVE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_IP     = 2'd0;
  localparam logic [1:0] CFG_OWN_MAC    = 2'd1;
  localparam logic [1:0] CFG_GATEWAY_IP = 2'd2;

  // ARP opcode for a request and the broadcast addresses.
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [31:0] BCAST_IP   = 32'hFFFF_FFFF;
  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;

  // Control from the sequencer to the cache memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } arc_mem_ctl_t;

endpackage

// ===== src/arc_cache_mem.sv =====
// Cache memory for learned IP and MAC pairs, with per-entry valid bits.
module arc_cache_mem
  import arc_pkg::*;
#(
  parameter int CACHE_DEPTH = 16,
  parameter int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  arc_mem_ctl_t  ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_ip,
  input  logic [47:0]   wr_mac,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_ip,
  output logic [47:0]   rd_mac
);

  logic [31:0] ip_mem [CACHE_DEPTH];
  logic [47:0] mac_mem [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] valid_r;
  logic [31:0] rd_ip_r;
  logic [47:0] rd_mac_r;
  logic        rd_vld_r;

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ip_mem[wr_addr]  <= wr_ip;
      mac_mem[wr_addr] <= wr_mac;
    end
    if (ctl.rd_en) begin
      rd_ip_r  <= ip_mem[rd_addr];
      rd_mac_r <= mac_mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_ip  = rd_vld_r ? rd_ip_r  : '0;
  assign rd_mac = rd_vld_r ? rd_mac_r : '0;

endmodule

// ===== src/arp_responder_cache.sv =====
// ARP responder top level: sequencer, configuration registers and result register.
// One item is taken at a time; in_stall stays high from the transfer until the
// result is loaded into the output register (or the item is finished without one).
// A request packet or a resolve goes through the decode and emit states; a packet that is
// learned or dropped ends in decode. A lookup scans the cache through the single read port
// of the cache memory, oldest entry first, one entry per cycle, and stops at the first match
// or after the last entry. The output register holds a result until it is taken; a later
// result waits in the sequencer until the register is free, and the input stays stalled
// meanwhile. The cache reads as all zeros after reset, with no clearing time.
module arp_responder_cache
  import arc_pkg::*;
#(
  parameter int CACHE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_rx_opcode,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_target_ip,
  input  logic [47:0] in_frame_src_mac,
  input  logic [31:0] in_query_ip,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [47:0] out_frame_dest_mac,
  output logic [47:0] out_arp_target_mac,
  output logic [31:0] out_arp_target_ip,
  output logic [47:0] out_lookup_mac,
  output logic [47:0] out_stored_gateway_mac
);

  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CACHE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(CACHE_DEPTH);
  localparam logic [CW-1:0] LAST_CNT  = CW'(CACHE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [31:0] own_ip_r;
  logic [47:0] own_mac_r;
  logic [31:0] gateway_ip_r;

  // Captured input item
  logic [1:0]  func_r;
  logic [15:0] opcode_r;
  logic [31:0] sender_ip_r;
  logic [47:0] sender_mac_r;
  logic [31:0] target_ip_r;
  logic [47:0] frame_src_mac_r;
  logic [31:0] query_ip_r;

  // Cache state
  logic [AW-1:0] oldest_slot_r;
  logic [47:0]   gateway_mac_r;

  // Scan control
  logic [AW-1:0] scan_addr_r;
  logic [CW-1:0] rd_cnt_r;
  logic [CW-1:0] cmp_cnt_r;
  logic          pend_r;

  // Pending result
  logic [1:0]  res_kind_r;
  logic [47:0] res_dest_r;
  logic [47:0] res_tmac_r;
  logic [31:0] res_tip_r;
  logic [47:0] res_lmac_r;

  // Output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [47:0] out_dest_r;
  logic [47:0] out_tmac_r;
  logic [31:0] out_tip_r;
  logic [47:0] out_lmac_r;
  logic [47:0] out_gw_r;

  arc_mem_ctl_t mem_ctl;
  logic [31:0]  rd_ip;
  logic [47:0]  rd_mac;
  logic         in_xfer;
  logic         out_free;
  logic         out_load;
  logic         target_ok;
  logic         rd_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_EMIT) && out_free;
  assign target_ok = (target_ip_r == own_ip_r) || (target_ip_r == BCAST_IP);
  assign rd_hit    = (rd_ip == query_ip_r);

  // Cache memory control: learn on an accepted non-request packet, read while scanning.
  always_comb begin
    mem_ctl.wr_en = (state_r == S_DECODE) && (func_r == FUNC_PACKET) && target_ok &&
                    (opcode_r != OP_REQUEST);
    mem_ctl.rd_en = (state_r == S_SCAN) && (rd_cnt_r != DEPTH_CNT);
  end

  arc_cache_mem #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_addr (oldest_slot_r),
    .wr_ip   (sender_ip_r),
    .wr_mac  (sender_mac_r),
    .rd_addr (scan_addr_r),
    .rd_ip   (rd_ip),
    .rd_mac  (rd_mac)
  );

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r     <= '0;
      own_mac_r    <= '0;
      gateway_ip_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_IP:     own_ip_r     <= cfg_wdata[31:0];
        CFG_OWN_MAC:    own_mac_r    <= cfg_wdata;
        CFG_GATEWAY_IP: gateway_ip_r <= cfg_wdata[31:0];
        default:        ;
      endcase
    end
  end

  // Sequencer with the result and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      oldest_slot_r <= '0;
      gateway_mac_r <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      rd_cnt_r      <= '0;
      cmp_cnt_r     <= '0;
      scan_addr_r   <= '0;
    end else begin
      // A new result fills the output register; an output transfer frees it.
      out_valid_r <= out_load || (out_valid_r && out_stall);

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            func_r          <= in_func;
            opcode_r        <= in_rx_opcode;
            sender_ip_r     <= in_sender_ip;
            sender_mac_r    <= in_sender_mac;
            target_ip_r     <= in_target_ip;
            frame_src_mac_r <= in_frame_src_mac;
            query_ip_r      <= in_query_ip;
            state_r         <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (func_r)
            FUNC_PACKET: begin
              if (target_ok && (opcode_r == OP_REQUEST)) begin
                res_kind_r <= KIND_REPLY;
                res_dest_r <= frame_src_mac_r;
                res_tmac_r <= sender_mac_r;
                res_tip_r  <= sender_ip_r;
                res_lmac_r <= '0;
                state_r    <= S_EMIT;
              end else begin
                state_r <= S_IDLE;
                if (target_ok) begin
                  // Learned pair overwrites the oldest slot.
                  oldest_slot_r <= (oldest_slot_r == LAST_SLOT) ? '0 : oldest_slot_r + 1'b1;
                  if (sender_ip_r == gateway_ip_r) begin
                    gateway_mac_r <= sender_mac_r;
                  end
                end
              end
            end
            FUNC_LOOKUP: begin
              scan_addr_r <= oldest_slot_r;
              rd_cnt_r    <= '0;
              cmp_cnt_r   <= '0;
              pend_r      <= 1'b0;
              state_r     <= S_SCAN;
            end
            FUNC_RESOLVE: begin
              res_kind_r <= KIND_REQUEST;
              res_dest_r <= BCAST_MAC;
              res_tmac_r <= BCAST_MAC;
              res_tip_r  <= query_ip_r;
              res_lmac_r <= '0;
              state_r    <= S_EMIT;
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end

        S_SCAN: begin
          // Issue one read per cycle, oldest to newest.
          if (mem_ctl.rd_en) begin
            rd_cnt_r    <= rd_cnt_r + 1'b1;
            scan_addr_r <= (scan_addr_r == LAST_SLOT) ? '0 : scan_addr_r + 1'b1;
          end
          pend_r <= mem_ctl.rd_en;
          // Compare the entry read in the previous cycle.
          if (pend_r) begin
            cmp_cnt_r <= cmp_cnt_r + 1'b1;
            if (rd_hit || (cmp_cnt_r == LAST_CNT)) begin
              res_kind_r <= KIND_LOOKUP;
              res_dest_r <= '0;
              res_tmac_r <= '0;
              res_tip_r  <= '0;
              res_lmac_r <= rd_hit ? rd_mac : '0;
              state_r    <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (out_load) begin
            out_kind_r  <= res_kind_r;
            out_dest_r  <= res_dest_r;
            out_tmac_r  <= res_tmac_r;
            out_tip_r   <= res_tip_r;
            out_lmac_r  <= res_lmac_r;
            out_gw_r    <= gateway_mac_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = out_kind_r;
  assign out_frame_dest_mac     = out_dest_r;
  assign out_arp_target_mac     = out_tmac_r;
  assign out_arp_target_ip      = out_tip_r;
  assign out_lookup_mac         = out_lmac_r;
  assign out_stored_gateway_mac = out_gw_r;

endmodule

// ===== tb/arp_responder_cache_test.sv =====
// Self-checking testbench for the ARP responder with its ring address cache.
`timescale 1ns / 1ps

module arp_responder_cache_test;
  import arc_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = DEPTH + 14;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int POOL_SIZE     = 24;

  // Codes the package does not name.
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  // Receiver stall patterns.
  localparam int STALL_NONE  = 0;
  localparam int STALL_HALF  = 1;
  localparam int STALL_HEAVY = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] rx_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [47:0] frame_src_mac;
    logic [31:0] query_ip;
  } arp_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] dest_mac;
    logic [47:0] tgt_mac;
    logic [31:0] tgt_ip;
    logic [47:0] lookup_mac;
    logic [47:0] gw_mac;
  } arp_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [15:0] in_rx_opcode = '0;
  logic [31:0] in_sender_ip = '0;
  logic [47:0] in_sender_mac = '0;
  logic [31:0] in_target_ip = '0;
  logic [47:0] in_frame_src_mac = '0;
  logic [31:0] in_query_ip = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [47:0] out_frame_dest_mac;
  logic [47:0] out_arp_target_mac;
  logic [31:0] out_arp_target_ip;
  logic [47:0] out_lookup_mac;
  logic [47:0] out_stored_gateway_mac;

  // Items waiting to be driven and answers the block still owes.
  arp_item_t   pending_items[$];
  arp_answer_t answers_due[$];

  // Predictor copy of the configuration and of the cache state.
  logic [31:0] own_ip_reg = '0;
  logic [47:0] own_mac_reg = '0;
  logic [31:0] gateway_ip_reg = '0;
  logic [31:0] learned_ip [0:DEPTH-1];
  logic [47:0] learned_mac [0:DEPTH-1];
  int          ring_head = 0;
  logic [47:0] gw_mac_seen = '0;

  logic [31:0] ip_pool [0:POOL_SIZE-1];
  bit          item_taken = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_mode = STALL_NONE;
  int          stall_left = 0;

  arp_responder_cache #(.CACHE_DEPTH(DEPTH)) dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Addresses are mostly drawn from a small pool so that lookups hit and entries repeat.
  function automatic logic [31:0] pick_ip();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (p < 75) return gateway_ip_reg;
    if (p < 85) return 32'd0;
    return $urandom;
  endfunction

  function automatic arp_item_t arp_item(logic [1:0] func, logic [15:0] op,
                                         logic [31:0] sip, logic [47:0] smac,
                                         logic [31:0] tip, logic [47:0] fsrc,
                                         logic [31:0] qip);
    arp_item_t it;
    it.func = func;
    it.rx_opcode = op;
    it.sender_ip = sip;
    it.sender_mac = smac;
    it.target_ip = tip;
    it.frame_src_mac = fsrc;
    it.query_ip = qip;
    return it;
  endfunction

  // Random item: mostly packets that pass the target filter, lookups and resolves.
  function automatic arp_item_t make_item();
    arp_item_t it;
    int p;
    it = arp_item(FUNC_PACKET, 16'($urandom_range(0, 16'hFFFF)), pick_ip(), rand48(),
                  $urandom, rand48(), $urandom);
    p = $urandom_range(0, 99);
    if (p < 42) begin
      p = $urandom_range(0, 9);
      if (p < 7) it.target_ip = own_ip_reg;
      else if (p < 9) it.target_ip = BCAST_IP;
      p = $urandom_range(0, 9);
      if (p < 4) it.rx_opcode = OP_REQUEST;
      else if (p < 7) it.rx_opcode = OP_REPLY;
    end else if (p < 77) begin
      it.func = FUNC_LOOKUP;
      it.query_ip = pick_ip();
    end else if (p < 96) begin
      it.func = FUNC_RESOLVE;
    end else begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  // Work out the answer an accepted item causes and update the cache state.
  task automatic predict_arp_answer(arp_item_t it);
    arp_answer_t ans;
    int slot;
    bit hit;
    ans = '0;
    ans.gw_mac = gw_mac_seen;
    hit = 1'b0;
    case (it.func)
      FUNC_PACKET: begin
        if (it.target_ip == own_ip_reg || it.target_ip == BCAST_IP) begin
          if (it.rx_opcode == OP_REQUEST) begin
            ans.kind = KIND_REPLY;
            ans.dest_mac = it.frame_src_mac;
            ans.tgt_mac = it.sender_mac;
            ans.tgt_ip = it.sender_ip;
            answers_due.push_back(ans);
          end else begin
            learned_ip[ring_head] = it.sender_ip;
            learned_mac[ring_head] = it.sender_mac;
            ring_head = (ring_head + 1) % DEPTH;
            if (it.sender_ip == gateway_ip_reg) gw_mac_seen = it.sender_mac;
          end
        end
      end
      FUNC_LOOKUP: begin
        // Oldest entry first; the first match wins.
        for (int i = 0; i < DEPTH; i++) begin
          slot = (ring_head + i) % DEPTH;
          if (!hit && learned_ip[slot] == it.query_ip) begin
            hit = 1'b1;
            ans.lookup_mac = learned_mac[slot];
          end
        end
        ans.kind = KIND_LOOKUP;
        answers_due.push_back(ans);
      end
      FUNC_RESOLVE: begin
        ans.kind = KIND_REQUEST;
        ans.dest_mac = BCAST_MAC;
        ans.tgt_mac = BCAST_MAC;
        ans.tgt_ip = it.query_ip;
        answers_due.push_back(ans);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string label, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic set_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_OWN_IP:     own_ip_reg = val[31:0];
      CFG_OWN_MAC:    own_mac_reg = val;
      CFG_GATEWAY_IP: gateway_ip_reg = val[31:0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(logic [31:0] own_ip, logic [47:0] own_mac, logic [31:0] gw_ip);
    set_reg(CFG_OWN_IP, {16'(rand48()), own_ip});
    set_reg(CFG_OWN_MAC, own_mac);
    set_reg(CFG_GATEWAY_IP, {16'(rand48()), gw_ip});
    set_reg(CFG_UNUSED, rand48());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item has been taken and answered, then let the block settle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) pending_items.push_back(make_item());
    wait_idle();
  endtask

  // Sample transfers on both channels and check each answer against the oldest one due.
  always @(posedge clk) begin
    arp_answer_t want;
    item_taken = rst_n && in_valid && !in_stall;
    if (item_taken) begin
      predict_arp_answer(arp_item(in_func, in_rx_opcode, in_sender_ip, in_sender_mac,
                                  in_target_ip, in_frame_src_mac, in_query_ip));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer, expected none, actual kind %0d", $time, out_kind);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        check_field("kind", 48'(want.kind), 48'(out_kind));
        check_field("frame_dest_mac", want.dest_mac, out_frame_dest_mac);
        check_field("arp_target_mac", want.tgt_mac, out_arp_target_mac);
        check_field("arp_target_ip", 48'(want.tgt_ip), 48'(out_arp_target_ip));
        check_field("lookup_mac", want.lookup_mac, out_lookup_mac);
        check_field("stored_gateway_mac", want.gw_mac, out_stored_gateway_mac);
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    arp_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        nxt = pending_items.pop_front();
        in_func <= nxt.func;
        in_rx_opcode <= nxt.rx_opcode;
        in_sender_ip <= nxt.sender_ip;
        in_sender_mac <= nxt.sender_mac;
        in_target_ip <= nxt.target_ip;
        in_frame_src_mac <= nxt.frame_src_mac;
        in_query_ip <= nxt.query_ip;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(10, 40);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // Receiver: a random stall pattern, drawn anew when the current one runs out.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
      default:    out_stall <= ($urandom_range(0, 6) != 0);
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL arp_responder_cache");
      $finish;
    end
  end

  initial begin
    logic [47:0] m1;
    logic [47:0] m2;
    logic [47:0] m3;
    for (int i = 0; i < DEPTH; i++) begin
      learned_ip[i] = '0;
      learned_mac[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    m1 = rand48();
    m2 = rand48();
    m3 = rand48();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration (own and gateway address zero).
    // Lookups in the cleared cache return zero, including for address zero.
    pending_items.push_back(arp_item(FUNC_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0, 32'd0));
    pending_items.push_back(arp_item(FUNC_LOOKUP, 16'hFFFF, BCAST_IP, BCAST_MAC, BCAST_IP,
                                     BCAST_MAC, BCAST_IP));
    pending_items.push_back(arp_item(FUNC_RESOLVE, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0, 32'd0));
    pending_items.push_back(arp_item(FUNC_RESOLVE, 16'hFFFF, BCAST_IP, BCAST_MAC, BCAST_IP,
                                     BCAST_MAC, BCAST_IP));
    // Requests to the own address and to broadcast are answered; others are dropped.
    pending_items.push_back(arp_item(FUNC_PACKET, OP_REQUEST, BCAST_IP, BCAST_MAC, 32'd0,
                                     BCAST_MAC, BCAST_IP));
    pending_items.push_back(arp_item(FUNC_PACKET, OP_REQUEST, 32'd0, 48'd0, BCAST_IP,
                                     48'd0, 32'd0));
    pending_items.push_back(arp_item(FUNC_PACKET, OP_REQUEST, 32'h0A00_0001, m1, 32'd1,
                                     m2, 32'd0));
    // Non-requests that pass the target filter are learned; sender zero matches the gateway address here.
    pending_items.push_back(arp_item(FUNC_PACKET, OP_REPLY, 32'h0A00_0001, m1, 32'd0,
                                     m3, 32'd0));
    pending_items.push_back(arp_item(FUNC_PACKET, 16'd0, 32'd0, m2, BCAST_IP, m1, 32'd0));
    pending_items.push_back(arp_item(FUNC_PACKET, 16'hFFFF, 32'h0A00_0002, m3,
                                     32'hFFFF_FFFE, m1, 32'd0));
    pending_items.push_back(arp_item(FUNC_UNUSED, 16'hFFFF, BCAST_IP, BCAST_MAC, BCAST_IP,
                                     BCAST_MAC, BCAST_IP));
    pending_items.push_back(arp_item(FUNC_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0,
                                     32'h0A00_0001));
    // Cleared slots are older than the learned zero entry, so this reads zero.
    pending_items.push_back(arp_item(FUNC_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0, 32'd0));
    pending_items.push_back(arp_item(FUNC_RESOLVE, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0,
                                     32'h0A00_0003));
    // A second entry for the same address; the older one still wins.
    pending_items.push_back(arp_item(FUNC_PACKET, OP_REPLY, 32'h0A00_0001, m3, 32'd0,
                                     m2, 32'd0));
    pending_items.push_back(arp_item(FUNC_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0,
                                     32'h0A00_0001));
    pending_items.push_back(arp_item(FUNC_LOOKUP, 16'd0, 32'd0, 48'd0, 32'd0, 48'd0,
                                     32'h0A00_0002));
    wait_idle();

    // Random phases, each under its own configuration.
    configure($urandom, rand48(), ip_pool[$urandom_range(0, POOL_SIZE - 1)]);
    run_random(350);
    configure(BCAST_IP, BCAST_MAC, BCAST_IP);
    run_random(350);
    configure(32'd0, 48'd0, 32'd0);
    run_random(350);
    configure($urandom, rand48(), ip_pool[$urandom_range(0, POOL_SIZE - 1)]);
    run_random(330);

    if (mismatches == 0) begin
      $display("PASS arp_responder_cache");
    end else begin
      $display("FAIL arp_responder_cache");
    end
    $finish;
  end

endmodule

// ===== arp_responder_cache.f =====
src/arc_pkg.sv
src/arc_cache_mem.sv
src/arp_responder_cache.sv
tb/arp_responder_cache_test.sv
